>>> rtl/rfp_pkg.sv
package rfp_pkg;

    // payload tags of the feedback frame
    localparam logic [7:0] TAG_BASIC   = 8'h01;
    localparam logic [7:0] TAG_DOCK_IR = 8'h03;
    localparam logic [7:0] TAG_INERT   = 8'h04;
    localparam logic [7:0] TAG_CLIFF   = 8'h05;
    localparam logic [7:0] TAG_CURRENT = 8'h06;
    localparam logic [7:0] TAG_HW_VER  = 8'h0A;
    localparam logic [7:0] TAG_FW_VER  = 8'h0B;
    localparam logic [7:0] TAG_GYRO    = 8'h0D;
    localparam logic [7:0] TAG_GPIO    = 8'h10;
    localparam logic [7:0] TAG_UDID    = 8'h13;

    // status codes of the end-of-frame record
    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_BAD_SUM  = 4'd1;
    localparam logic [3:0] ST_OVERRUN  = 4'd12;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int RECS_PER_BEAT = 3;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_BODY = 4'b0100,
        PH_SKIP = 4'b1000
    } t_phase;

    typedef struct packed {
        logic        kind;
        logic [5:0]  code;
        logic [6:0]  sample;
        logic [31:0] value;
        logic [3:0]  status;
        logic        last;
    } t_rec;

    // records caused by one input beat, rec[0] goes out first
    typedef struct packed {
        logic [1:0]                   cnt;
        t_rec [RECS_PER_BEAT-1:0]     rec;
    } t_bundle;

    // expected content length, 0 for unknown tags, 1 marks the gyro tag
    function automatic logic [7:0] tag_len(input logic [7:0] t);
        logic [7:0] l;
        case (t)
            TAG_BASIC:   l = 8'h0F;
            TAG_DOCK_IR: l = 8'h03;
            TAG_INERT:   l = 8'h07;
            TAG_CLIFF:   l = 8'h06;
            TAG_CURRENT: l = 8'h02;
            TAG_HW_VER:  l = 8'h04;
            TAG_FW_VER:  l = 8'h04;
            TAG_GPIO:    l = 8'h10;
            TAG_UDID:    l = 8'h0C;
            TAG_GYRO:    l = 8'h01;
            default:     l = 8'h00;
        endcase
        return l;
    endfunction

    function automatic logic [3:0] tag_err(input logic [7:0] t);
        logic [3:0] e;
        case (t)
            TAG_BASIC:   e = 4'd2;
            TAG_DOCK_IR: e = 4'd3;
            TAG_INERT:   e = 4'd4;
            TAG_CLIFF:   e = 4'd5;
            TAG_CURRENT: e = 4'd6;
            TAG_HW_VER:  e = 4'd7;
            TAG_FW_VER:  e = 4'd8;
            TAG_GYRO:    e = 4'd9;
            TAG_GPIO:    e = 4'd10;
            default:     e = 4'd11;
        endcase
        return e;
    endfunction

    function automatic t_rec mk_field(input logic [5:0] code, input logic [6:0] sample,
                                      input logic [31:0] value);
        t_rec r;
        r.kind   = 1'b0;
        r.code   = code;
        r.sample = sample;
        r.value  = value;
        r.status = ST_OK;
        r.last   = 1'b0;
        return r;
    endfunction

endpackage

>>> rtl/rfp_front.sv
module rfp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_first,
    input  logic             i_full,
    output logic             o_ready,
    output logic             o_push,
    output rfp_pkg::t_bundle o_bundle
);
    import rfp_pkg::*;

    logic [7:0]  r_len, r_pos, r_xor, r_tag, r_off, r_skip;
    logic [31:0] r_val;
    logic [6:0]  r_gyro, r_gi;
    logic [2:0]  r_gr;
    logic [3:0]  r_err;
    logic        r_active;
    t_phase      r_phase;

    logic [7:0]  n_len, n_pos, n_xor, n_tag, n_off, n_skip;
    logic [31:0] n_val;
    logic [6:0]  n_gyro, n_gi;
    logic [2:0]  n_gr;
    logic [3:0]  n_err;
    logic        n_active;
    t_phase      n_phase;
    t_bundle     bnd;
    logic        accept;

    assign o_ready  = !i_full;
    assign accept   = i_valid && !i_full;
    assign o_push   = accept && (bnd.cnt != 2'd0);
    assign o_bundle = bnd;

    always_comb begin
        logic [7:0]  b, o, want, third;
        logic [15:0] prod;
        logic        done;
        logic [31:0] va;
        b     = i_byte;
        o     = r_off;
        done  = 1'b0;
        prod  = 16'(b) * 16'd171;
        third = 8'(prod >> 9);
        want  = tag_len(r_tag);
        va    = r_val | (32'(b) << 8);
        n_len = r_len; n_pos = r_pos; n_xor = r_xor; n_tag = r_tag; n_off = r_off;
        n_skip = r_skip; n_val = r_val; n_gyro = r_gyro; n_gi = r_gi; n_gr = r_gr;
        n_err = r_err; n_active = r_active; n_phase = r_phase;
        bnd = '0;
        if (i_first) begin
            n_len = b; n_pos = '0; n_xor = b; n_tag = '0; n_off = '0; n_skip = '0;
            n_val = '0; n_gyro = '0; n_gi = '0; n_gr = '0; n_err = ST_OK;
            n_active = 1'b1; n_phase = PH_IDLE;
        end else if (r_active) begin
            n_xor = r_xor ^ b;
            if (r_pos == r_len) begin
                bnd.cnt           = 2'd1;
                bnd.rec[0]        = '0;
                bnd.rec[0].kind   = 1'b1;
                bnd.rec[0].status = (n_xor != 8'd0) ? ST_BAD_SUM : r_err;
                bnd.rec[0].last   = 1'b1;
                n_active          = 1'b0;
            end else begin
                n_pos = r_pos + 8'd1;
                if (r_err == ST_OK) begin
                    case (r_phase)
                        PH_IDLE: begin
                            if (n_pos < r_len) begin
                                n_tag = b; n_phase = PH_LEN;
                            end
                        end
                        PH_LEN: begin
                            if (want == 8'd0) begin
                                n_skip  = b;
                                n_phase = (b != 8'd0) ? PH_SKIP : PH_IDLE;
                            end else if ((want == 8'd1) ? b[0] : (b != want)) begin
                                n_err = tag_err(r_tag);
                            end else begin
                                n_off = '0; n_gr = '0; n_gi = '0; n_phase = PH_BODY;
                            end
                        end
                        PH_BODY: begin
                            case (r_tag)
                                TAG_BASIC: begin
                                    if (o <= 8'd1) begin
                                        if (o == 8'd0) n_val = 32'(b);
                                        else begin
                                            bnd.cnt = 2'd1;
                                            bnd.rec[0] = mk_field(6'd0, 7'd0, va);
                                        end
                                    end else if (o == 8'd2) begin
                                        bnd.cnt = 2'd3;
                                        bnd.rec[0] = mk_field(6'd1, 7'd0, 32'(b & 8'h02));
                                        bnd.rec[1] = mk_field(6'd2, 7'd0, 32'(b & 8'h04));
                                        bnd.rec[2] = mk_field(6'd3, 7'd0, 32'(b & 8'h01));
                                    end else if (o == 8'd3) begin
                                        bnd.cnt = 2'd2;
                                        bnd.rec[0] = mk_field(6'd4, 7'd0, 32'(b & 8'h02));
                                        bnd.rec[1] = mk_field(6'd5, 7'd0, 32'(b & 8'h01));
                                    end else if (o == 8'd4) begin
                                        bnd.cnt = 2'd3;
                                        bnd.rec[0] = mk_field(6'd6, 7'd0, 32'(b & 8'h02));
                                        bnd.rec[1] = mk_field(6'd7, 7'd0, 32'(b & 8'h04));
                                        bnd.rec[2] = mk_field(6'd8, 7'd0, 32'(b & 8'h01));
                                    end else if (o <= 8'd6) begin
                                        if (o == 8'd5) n_val = 32'(b);
                                        else begin
                                            bnd.cnt = 2'd1;
                                            bnd.rec[0] = mk_field(6'd9, 7'd0, va);
                                        end
                                    end else if (o <= 8'd8) begin
                                        if (o == 8'd7) n_val = 32'(b);
                                        else begin
                                            bnd.cnt = 2'd1;
                                            bnd.rec[0] = mk_field(6'd10, 7'd0, va);
                                        end
                                    end else begin
                                        bnd.cnt = 2'd1;
                                        bnd.rec[0] = mk_field(6'(o + 8'd2), 7'd0, 32'(b));
                                    end
                                end
                                TAG_DOCK_IR, TAG_CURRENT: begin
                                    bnd.cnt = 2'd1;
                                    bnd.rec[0] = mk_field(
                                        6'(o + ((r_tag == TAG_DOCK_IR) ? 8'd17 : 8'd25)),
                                        7'd0, 32'(b));
                                end
                                TAG_HW_VER, TAG_FW_VER: begin
                                    if (o < 8'd3) begin
                                        bnd.cnt = 2'd1;
                                        bnd.rec[0] = mk_field(
                                            6'(o + ((r_tag == TAG_HW_VER) ? 8'd27 : 8'd30)),
                                            7'd0, 32'(b));
                                    end
                                end
                                TAG_INERT, TAG_CLIFF, TAG_GPIO: begin
                                    if ((r_tag == TAG_CLIFF) || (r_tag == TAG_INERT && o < 8'd4)
                                        || (r_tag == TAG_GPIO && o < 8'd10)) begin
                                        if (!o[0]) n_val = 32'(b);
                                        else begin
                                            bnd.cnt = 2'd1;
                                            bnd.rec[0] = mk_field(6'((o >> 1) +
                                                ((r_tag == TAG_INERT) ? 8'd20 :
                                                 (r_tag == TAG_CLIFF) ? 8'd22 : 8'd37)),
                                                7'd0, va);
                                        end
                                    end
                                end
                                TAG_UDID: begin
                                    if (o[1:0] == 2'd0) n_val = 32'(b);
                                    else n_val = r_val | (32'(b) << {o[1:0], 3'd0});
                                    if (o[1:0] == 2'd3) begin
                                        bnd.cnt = 2'd1;
                                        bnd.rec[0] = mk_field(6'((o >> 2) + 8'd42), 7'd0, n_val);
                                    end
                                end
                                default: ;
                            endcase
                            if (r_tag == TAG_GYRO) begin
                                if (o == 8'd0) begin
                                    bnd.cnt = 2'd1;
                                    bnd.rec[0] = mk_field(6'd33, 7'd0, 32'(b));
                                end else if (o == 8'd1) begin
                                    n_gyro = third[6:0];
                                    done   = (third[6:0] == 7'd0);
                                end else begin
                                    if (!r_gr[0]) n_val = 32'(b);
                                    else begin
                                        bnd.cnt = 2'd1;
                                        bnd.rec[0] = mk_field(6'(6'd34 + 6'(r_gr >> 1)), r_gi, va);
                                    end
                                    if (r_gr == 3'd5) begin
                                        n_gr   = '0;
                                        n_gi   = r_gi + 7'd1;
                                        n_gyro = r_gyro - 7'd1;
                                        done   = (n_gyro == 7'd0);
                                    end else begin
                                        n_gr = r_gr + 3'd1;
                                    end
                                end
                            end else begin
                                done = ({1'b0, o} + 9'd1) >= {1'b0, want};
                            end
                            n_off = r_off + 8'd1;
                            if (done) n_phase = PH_IDLE;
                        end
                        PH_SKIP: begin
                            n_skip = r_skip - 8'd1;
                            if (n_skip == 8'd0) n_phase = PH_IDLE;
                        end
                        default: n_phase = PH_IDLE;
                    endcase
                    if (n_pos == r_len && n_phase != PH_IDLE && n_err == ST_OK)
                        n_err = ST_OVERRUN;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0; r_pos <= '0; r_xor <= '0; r_tag <= '0; r_off <= '0;
            r_skip <= '0; r_val <= '0; r_gyro <= '0; r_gi <= '0; r_gr <= '0;
            r_err <= ST_OK; r_active <= 1'b0; r_phase <= PH_IDLE;
        end else if (accept) begin
            r_len <= n_len; r_pos <= n_pos; r_xor <= n_xor; r_tag <= n_tag;
            r_off <= n_off; r_skip <= n_skip; r_val <= n_val; r_gyro <= n_gyro;
            r_gi <= n_gi; r_gr <= n_gr; r_err <= n_err; r_active <= n_active;
            r_phase <= n_phase;
        end
    end

endmodule

>>> rtl/rfp_queue.sv
module rfp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rfp_pkg::t_bundle i_din,
    input  logic             i_pop,
    output rfp_pkg::t_bundle o_dout,
    output logic             o_full,
    output logic             o_empty
);
    import rfp_pkg::*;

    t_bundle             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QPTR_W:0]     r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_dout  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_din;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_count <= r_count + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

>>> rtl/rfp_back.sv
module rfp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rfp_pkg::t_bundle i_head,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    output rfp_pkg::t_rec    o_rec,
    input  logic             i_ready
);
    import rfp_pkg::*;

    logic [1:0] r_sel;
    logic       r_valid;
    t_rec       r_rec;
    logic       load;

    assign load    = (!r_valid || i_ready) && !i_empty;
    assign o_pop   = load && (r_sel == i_head.cnt - 2'd1);
    assign o_valid = r_valid;
    assign o_rec   = r_rec;

    always_ff @(posedge i_clk) begin
        if (load) r_rec <= i_head.rec[r_sel];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= '0;
        end else begin
            if (load) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
            if (o_pop) r_sel <= '0;
            else if (load) r_sel <= r_sel + 2'd1;
        end
    end

endmodule

>>> rtl/robot_feedback_frame_parser.sv
// feedback frame parser: takes one frame byte per beat (length byte flagged by
// s_axis_tuser, payload, xor checksum) and emits little-endian field records as
// sub-payload bytes arrive, then one status record (tlast) after the checksum
// byte. field records are provisional until that status says ok. a byte is
// accepted every cycle while the 4-entry record-group queue has room; a byte
// that yields two or three records (bumper, wheel drop, cliff bits) leaves
// through the single output register one record at a time, so the sustained
// rate is one byte per cycle until the queue fills, then set by the record count per byte
module robot_feedback_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] frame_first
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] field_code, [12:6] sample_index, [44:13] field_value,
    // [48:45] status_code, [55:49] zero
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tuser,   // [0] record_kind
    output logic        m_axis_tlast    // last
);
    import rfp_pkg::*;

    // front to queue
    t_bundle push_bnd;
    logic    push;
    // queue to back
    t_bundle head;
    logic    full, empty, pop;
    t_rec    out_rec;

    // front: length, position, running xor and sub-payload walk
    rfp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_byte   (s_axis_tdata),
        .i_first  (s_axis_tuser),
        .i_full   (full),
        .o_ready  (s_axis_tready),
        .o_push   (push),
        .o_bundle (push_bnd)
    );

    // per-beat record groups wait here
    rfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_din   (push_bnd),
        .i_pop   (pop),
        .o_dout  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    // back: one record per output beat
    rfp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .o_rec   (out_rec),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {7'd0, out_rec.status, out_rec.value, out_rec.sample, out_rec.code};
    assign m_axis_tuser = out_rec.kind;
    assign m_axis_tlast = out_rec.last;

endmodule
